>>> rtl/core/tcds_pkg.sv
// Shared constants, types and tables of the triangle circle direction sampler.
`timescale 1ns / 1ps

package tcds_pkg;

  // Field widths.
  localparam int COORD_W = 32;
  localparam int DIR_W   = 16;
  localparam int IDX_W   = 6;
  localparam int CNT_W   = 7;
  localparam int RAD_W   = 31;

  // Largest number of circle points per triangle.
  localparam int MAX_POINTS = 64;

  // Unit length in Q2.14.
  localparam int ONE_Q14 = 16384;

  // Rotation steps and the start value that cancels the rotation gain, Q1.30.
  localparam int CORDIC_STEPS    = 20;
  localparam int CORDIC_GAIN_INV = 652032874;

  // Division by three as a multiply: (2^35 + 1) / 3, exact for dividends below 2^35.
  localparam logic [33:0] DIV3_RECIP = 34'h2_AAAA_AAAB;

  // Step angles as fractions of a full turn, 2^32 per turn.
  localparam logic signed [32:0] ATAN_TURN [0:CORDIC_STEPS-1] = '{
    33'sh020000000, 33'sh012E4051E, 33'sh009FB385B, 33'sh0051111D4, 33'sh0028B0D43,
    33'sh00145D7E1, 33'sh000A2F61E, 33'sh000517C55, 33'sh00028BE53, 33'sh000145F2F,
    33'sh0000A2F98, 33'sh0000517CC, 33'sh000028BE6, 33'sh0000145F3, 33'sh00000A2FA,
    33'sh00000517D, 33'sh0000028BE, 33'sh00000145F, 33'sh000000A30, 33'sh000000518
  };

  // Configuration register indexes.
  localparam logic [1:0] REG_RADIUS = 2'd0;
  localparam logic [1:0] REG_COUNT  = 2'd1;

  // Side information that rides along with each circle point.
  typedef struct packed {
    logic             last;
    logic [IDX_W-1:0] idx;
  } tag_t;

  // One Q2.14 direction component.
  typedef logic signed [DIR_W-1:0] dir_t;

endpackage

>>> rtl/core/tcds_if.sv
// Valid/ready channel interfaces for triangles in and directions out.
`timescale 1ns / 1ps

interface tcds_in_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [tcds_pkg::COORD_W-1:0]     vertex_a_x;
  logic signed [tcds_pkg::COORD_W-1:0]     vertex_a_y;
  logic signed [tcds_pkg::COORD_W-1:0]     vertex_a_z;
  logic signed [tcds_pkg::COORD_W-1:0]     vertex_b_x;
  logic signed [tcds_pkg::COORD_W-1:0]     vertex_b_y;
  logic signed [tcds_pkg::COORD_W-1:0]     vertex_b_z;
  logic signed [tcds_pkg::COORD_W-1:0]     vertex_c_x;
  logic signed [tcds_pkg::COORD_W-1:0]     vertex_c_y;
  logic signed [tcds_pkg::COORD_W-1:0]     vertex_c_z;
  logic signed [tcds_pkg::COORD_W-1:0]     pos_x;
  logic signed [tcds_pkg::COORD_W-1:0]     pos_y;
  logic signed [tcds_pkg::COORD_W-1:0]     pos_z;

  modport source (
    output valid, vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x, vertex_b_y, vertex_b_z,
           vertex_c_x, vertex_c_y, vertex_c_z, pos_x, pos_y, pos_z,
    input  ready
  );
  modport sink (
    input  valid, vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x, vertex_b_y, vertex_b_z,
           vertex_c_x, vertex_c_y, vertex_c_z, pos_x, pos_y, pos_z,
    output ready
  );
endinterface

interface tcds_out_if;
  logic                          valid;
  logic                          ready;
  logic signed [tcds_pkg::DIR_W-1:0] dir_x;
  logic signed [tcds_pkg::DIR_W-1:0] dir_y;
  logic signed [tcds_pkg::DIR_W-1:0] dir_z;
  logic [tcds_pkg::IDX_W-1:0]    point_index;
  logic                          last;

  modport source (output valid, dir_x, dir_y, dir_z, point_index, last, input ready);
  modport sink (input valid, dir_x, dir_y, dir_z, point_index, last, output ready);
endinterface

>>> rtl/core/tcds_unit3.sv
// Pipelined vector normalizer: scale, square root and three dividers to Q2.14.
`timescale 1ns / 1ps

module tcds_unit3 (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [63:0]   in_x,
  input  logic signed [63:0]   in_y,
  input  logic signed [63:0]   in_z,
  input  tcds_pkg::tag_t       in_tag,
  output logic                 out_valid,
  output tcds_pkg::dir_t       out_x,
  output tcds_pkg::dir_t       out_y,
  output tcds_pkg::dir_t       out_z,
  output tcds_pkg::tag_t       out_tag
);

  localparam int SQ_STEPS = 32;
  localparam int DV_STEPS = 15;

  // Stage 0: magnitudes and signs.
  logic                 v0;
  logic [62:0]          m0 [0:2];
  logic [2:0]           ng0;
  tcds_pkg::tag_t       t0;
  // Stage 1: bit length of the largest magnitude.
  logic                 v1;
  logic [62:0]          m1 [0:2];
  logic [2:0]           ng1;
  logic                 zr1;
  logic [6:0]           len1;
  tcds_pkg::tag_t       t1;
  // Stage 2: scaled magnitudes.
  logic                 v2;
  logic [29:0]          nm2 [0:2];
  logic [2:0]           ng2;
  logic                 zr2;
  tcds_pkg::tag_t       t2;
  // Stage 3: squares.
  logic                 v3;
  logic [59:0]          sq3 [0:2];
  logic [29:0]          nm3 [0:2];
  logic [2:0]           ng3;
  logic                 zr3;
  tcds_pkg::tag_t       t3;
  // Square root stages, index 0 holds the sum of squares.
  logic                 sv_v  [0:SQ_STEPS];
  logic [61:0]          sv_r  [0:SQ_STEPS];
  logic [62:0]          sr_r  [0:SQ_STEPS];
  logic [29:0]          s_nm  [0:SQ_STEPS][0:2];
  logic [2:0]           s_ng  [0:SQ_STEPS];
  logic                 s_zr  [0:SQ_STEPS];
  tcds_pkg::tag_t       s_t   [0:SQ_STEPS];
  logic [63:0]          sq_trial [0:SQ_STEPS-1];
  logic                 sq_ge    [0:SQ_STEPS-1];
  // Divider stages, index 0 holds the rounded numerators.
  logic                 d_v   [0:DV_STEPS];
  logic [45:0]          d_rem [0:DV_STEPS][0:2];
  logic [14:0]          d_q   [0:DV_STEPS][0:2];
  logic [31:0]          d_r   [0:DV_STEPS];
  logic [2:0]           d_ng  [0:DV_STEPS];
  logic                 d_zr  [0:DV_STEPS];
  tcds_pkg::tag_t       d_t   [0:DV_STEPS];
  logic [45:0]          dv_sub [0:DV_STEPS-1];

  logic [62:0]          mx0;
  logic [6:0]           len0;
  logic [31:0]          root;

  // Leading one of the combined magnitude.
  always_comb begin
    mx0  = m0[0] | m0[1] | m0[2];
    len0 = '0;
    for (int i = 0; i < 63; i++) begin
      if (mx0[i]) len0 = 7'(i + 1);
    end
  end

  // Trial subtractions of the square root and the dividers.
  always_comb begin
    for (int k = 0; k < SQ_STEPS; k++) begin
      sq_trial[k] = {1'b0, sr_r[k]} + (64'd1 << (62 - 2 * k));
      sq_ge[k]    = ({2'b00, sv_r[k]} >= sq_trial[k]);
    end
    for (int k = 0; k < DV_STEPS; k++) begin
      dv_sub[k] = {14'd0, d_r[k]} << (DV_STEPS - 1 - k);
    end
  end

  assign root = sr_r[SQ_STEPS][31:0];

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      for (int k = 0; k <= SQ_STEPS; k++) sv_v[k] <= 1'b0;
      for (int k = 0; k <= DV_STEPS; k++) d_v[k] <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
      sv_v[0] <= v3;
      for (int k = 0; k < SQ_STEPS; k++) sv_v[k+1] <= sv_v[k];
      d_v[0] <= sv_v[SQ_STEPS];
      for (int k = 0; k < DV_STEPS; k++) d_v[k+1] <= d_v[k];
      out_valid <= d_v[DV_STEPS];
    end
  end

  // Data path.
  always_ff @(posedge clk) begin
    if (en) begin
      // Magnitudes and signs.
      m0[0] <= in_x[63] ? 63'(-in_x) : in_x[62:0];
      m0[1] <= in_y[63] ? 63'(-in_y) : in_y[62:0];
      m0[2] <= in_z[63] ? 63'(-in_z) : in_z[62:0];
      ng0   <= {in_z[63], in_y[63], in_x[63]};
      t0    <= in_tag;

      // Bit length.
      m1   <= m0;
      ng1  <= ng0;
      zr1  <= (mx0 == '0);
      len1 <= len0;
      t1   <= t0;

      // Bring the largest magnitude into [2^29, 2^30).
      for (int j = 0; j < 3; j++) begin
        if (len1 > 7'd30) nm2[j] <= 30'(m1[j] >> (len1 - 7'd30));
        else              nm2[j] <= 30'(m1[j] << (7'd30 - len1));
      end
      ng2 <= ng1;
      zr2 <= zr1;
      t2  <= t1;

      // Squares.
      for (int j = 0; j < 3; j++) sq3[j] <= 60'(nm2[j]) * 60'(nm2[j]);
      nm3 <= nm2;
      ng3 <= ng2;
      zr3 <= zr2;
      t3  <= t2;

      // Sum of squares.
      sv_r[0] <= 62'(sq3[0]) + 62'(sq3[1]) + 62'(sq3[2]);
      sr_r[0] <= '0;
      s_nm[0] <= nm3;
      s_ng[0] <= ng3;
      s_zr[0] <= zr3;
      s_t[0]  <= t3;

      // Integer square root, one result bit per stage.
      for (int k = 0; k < SQ_STEPS; k++) begin
        if (sq_ge[k]) begin
          sv_r[k+1] <= sv_r[k] - sq_trial[k][61:0];
          sr_r[k+1] <= (sr_r[k] >> 1) + 63'(64'd1 << (62 - 2 * k));
        end else begin
          sv_r[k+1] <= sv_r[k];
          sr_r[k+1] <= sr_r[k] >> 1;
        end
        s_nm[k+1] <= s_nm[k];
        s_ng[k+1] <= s_ng[k];
        s_zr[k+1] <= s_zr[k];
        s_t[k+1]  <= s_t[k];
      end

      // Rounded numerators.
      for (int j = 0; j < 3; j++) begin
        d_rem[0][j] <= {2'b00, s_nm[SQ_STEPS][j], 14'd0} + {15'd0, root[31:1]};
        d_q[0][j]   <= '0;
      end
      d_r[0]  <= root;
      d_ng[0] <= s_ng[SQ_STEPS];
      d_zr[0] <= s_zr[SQ_STEPS];
      d_t[0]  <= s_t[SQ_STEPS];

      // Restoring division, one quotient bit per stage from the top.
      for (int k = 0; k < DV_STEPS; k++) begin
        for (int j = 0; j < 3; j++) begin
          if (d_rem[k][j] >= dv_sub[k]) begin
            d_rem[k+1][j] <= d_rem[k][j] - dv_sub[k];
            d_q[k+1][j]   <= d_q[k][j] | (15'd1 << (DV_STEPS - 1 - k));
          end else begin
            d_rem[k+1][j] <= d_rem[k][j];
            d_q[k+1][j]   <= d_q[k][j];
          end
        end
        d_r[k+1]  <= d_r[k];
        d_ng[k+1] <= d_ng[k];
        d_zr[k+1] <= d_zr[k];
        d_t[k+1]  <= d_t[k];
      end

      // Signs back on; a zero vector stays zero.
      if (d_zr[DV_STEPS]) begin
        out_x <= '0;
        out_y <= '0;
        out_z <= '0;
      end else begin
        out_x <= d_ng[DV_STEPS][0] ? -16'(d_q[DV_STEPS][0]) : 16'(d_q[DV_STEPS][0]);
        out_y <= d_ng[DV_STEPS][1] ? -16'(d_q[DV_STEPS][1]) : 16'(d_q[DV_STEPS][1]);
        out_z <= d_ng[DV_STEPS][2] ? -16'(d_q[DV_STEPS][2]) : 16'(d_q[DV_STEPS][2]);
      end
      out_tag <= d_t[DV_STEPS];
    end
  end

endmodule

>>> rtl/core/triangle_circle_direction_sampler_top.sv
// Top level: triangle setup sequencer, circle point pipeline and output normalizer.
`timescale 1ns / 1ps

// One triangle and an observer position go in; point_count unit directions (Q2.14) come
// out, one per evenly spaced point on a circle of circle_radius around the centroid,
// the last flagged. The setup runs the normal, the first basis vector and the second basis
// vector one after another through a 54-stage normalizer (the vertical-normal case skips
// the middle pass), then the circle points stream out at one per cycle through a 20-stage
// rotation pipeline and a second normalizer, and the next triangle is taken once the last
// point has left the rotation and offset stages. Output stalls hold the whole point
// pipeline without loss.
module triangle_circle_direction_sampler_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [tcds_pkg::RAD_W-1:0]   cfg_data,
  tcds_in_if.sink                      in_ch,
  tcds_out_if.source                   out_ch
);

  localparam int NS = tcds_pkg::CORDIC_STEPS;

  typedef enum logic [3:0] {
    ST_IDLE, ST_EDGE, ST_SHIFT, ST_CROSS, ST_FEED_N, ST_WAIT_N,
    ST_FEED_U, ST_WAIT_U, ST_FEED_W, ST_WAIT_W, ST_POINTS, ST_DRAIN
  } state_t;

  state_t st;

  // Configuration registers.
  logic [tcds_pkg::RAD_W-1:0] radius;
  logic [tcds_pkg::CNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= tcds_pkg::RAD_W'(65536);
      count  <= tcds_pkg::CNT_W'(tcds_pkg::MAX_POINTS);
    end else if (cfg_we) begin
      unique case (cfg_index)
        tcds_pkg::REG_RADIUS: radius <= cfg_data;
        tcds_pkg::REG_COUNT:  count  <= cfg_data[tcds_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Triangle registers.
  logic signed [31:0] vtx [0:8];
  logic signed [31:0] pos [0:2];
  logic [6:0]         cnt;
  logic [6:0]         cnt_eff;
  logic signed [32:0] e  [0:5];
  logic signed [30:0] es [0:5];
  logic signed [61:0] pr [0:5];
  tcds_pkg::dir_t     n  [0:2];
  tcds_pkg::dir_t     u  [0:2];
  tcds_pkg::dir_t     w  [0:2];
  logic signed [31:0] wp [0:5];

  // Setup normalizer feed and result.
  logic               fd_fire;
  logic               fd_valid;
  logic signed [63:0] fd_x, fd_y, fd_z;
  logic               su_valid;
  tcds_pkg::dir_t     su_x, su_y, su_z;

  // Phase step divider.
  logic [34:0]        dv_num;
  logic [6:0]         dv_rem;
  logic [5:0]         dv_cnt;
  logic [7:0]         dv_t;

  // Centroid.
  logic signed [33:0] sum3 [0:2];
  logic [33:0]        smag [0:2];
  logic [33:0]        cmag [0:2];
  logic [2:0]         cen_neg;
  logic [50:0]        cp_lo [0:2];
  logic [50:0]        cp_hi [0:2];
  logic [67:0]        cp_sum [0:2];
  logic signed [33:0] cen [0:2];

  // Point generator.
  logic [31:0]        gq;
  logic [6:0]         grem;
  logic [5:0]         gidx;
  logic [7:0]         grem_sum;
  logic               grem_wrap;
  logic               glast;
  logic               gen_fire;
  logic [31:0]        ph_t;
  logic [31:0]        ph;

  // Edge shift.
  logic [32:0]        emag [0:5];
  logic [32:0]        emax;
  logic [1:0]         esh;

  // Point pipeline.
  logic               en;
  logic               cv [0:NS];
  logic signed [32:0] cx [0:NS];
  logic signed [32:0] cy [0:NS];
  logic signed [32:0] cz [0:NS];
  logic               cneg [0:NS];
  tcds_pkg::tag_t     ct [0:NS];
  logic signed [32:0] xf, yf;
  logic               vr, va, vb, vc, vd;
  logic signed [16:0] cs_r, sn_r;
  logic signed [32:0] pa [0:2];
  logic signed [32:0] pb [0:2];
  logic signed [33:0] nq [0:2];
  logic signed [63:0] rp [0:2];
  logic signed [63:0] rnd [0:2];
  logic signed [37:0] dd [0:2];
  logic signed [31:0] rad_s;
  tcds_pkg::tag_t     tr, ta, tb, tc, td;
  logic               front_busy;

  // Output normalizer.
  logic               pu_valid;
  tcds_pkg::dir_t     pu_x, pu_y, pu_z;
  tcds_pkg::tag_t     pu_tag;

  assign in_ch.ready = (st == ST_IDLE);
  assign en          = !pu_valid || out_ch.ready;
  assign gen_fire    = (st == ST_POINTS) && en;

  // A vector goes to the setup normalizer in each feed state, except for a vertical or zero normal.
  assign fd_fire = (st == ST_FEED_N) || (st == ST_FEED_W) ||
                   ((st == ST_FEED_U) && (n[0] != '0 || n[1] != '0));

  // Effective point count, edge magnitudes and shift, centroid terms, divider bits and cross products.
  always_comb begin
    if (count > 7'(tcds_pkg::MAX_POINTS)) cnt_eff = 7'(tcds_pkg::MAX_POINTS);
    else if (count == '0)                 cnt_eff = 7'd1;
    else                                  cnt_eff = count;
    emax = '0;
    for (int i = 0; i < 6; i++) begin
      emag[i] = e[i][32] ? 33'(-e[i]) : e[i];
      emax    = emax | emag[i];
    end
    priority if (emax[32]) esh = 2'd3;
    else if (emax[31])     esh = 2'd2;
    else if (emax[30])     esh = 2'd1;
    else                   esh = 2'd0;
    for (int j = 0; j < 3; j++) begin
      sum3[j]   = 34'(vtx[j]) + 34'(vtx[3+j]) + 34'(vtx[6+j]);
      smag[j]   = (sum3[j][33] ? 34'(-sum3[j]) : sum3[j]) + 34'd1;
      cp_sum[j] = {cp_hi[j], 17'd0} + 68'(cp_lo[j]);
    end
    dv_t = {dv_rem, dv_num[34]};
    wp[0] = 32'(n[1]) * 32'(u[2]);
    wp[1] = 32'(n[2]) * 32'(u[1]);
    wp[2] = 32'(n[2]) * 32'(u[0]);
    wp[3] = 32'(n[0]) * 32'(u[2]);
    wp[4] = 32'(n[0]) * 32'(u[1]);
    wp[5] = 32'(n[1]) * 32'(u[0]);
  end

  // Next phase: add the whole step, then carry the remainder once.
  always_comb begin
    grem_sum  = {1'b0, grem} + {1'b0, dv_rem};
    grem_wrap = (grem_sum >= {1'b0, cnt});
    glast     = ({1'b0, gidx} == (cnt - 7'd1));
    ph_t      = gq + 32'h4000_0000;
    ph        = ph_t[31] ? gq + 32'h8000_0000 : gq;
  end

  // Phase step 2^32 / count, one quotient bit per cycle during the setup.
  always_ff @(posedge clk) begin
    if (rst) begin
      dv_cnt <= '0;
    end else if (st == ST_EDGE) begin
      dv_num <= 35'h1_0000_0000;
      dv_rem <= '0;
      dv_cnt <= 6'd35;
    end else if (dv_cnt != '0) begin
      if (dv_t >= {1'b0, cnt}) begin
        dv_rem <= 7'(dv_t - {1'b0, cnt});
        dv_num <= {dv_num[33:0], 1'b1};
      end else begin
        dv_rem <= dv_t[6:0];
        dv_num <= {dv_num[33:0], 1'b0};
      end
      dv_cnt <= dv_cnt - 6'd1;
    end
  end

  // Setup sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= ST_IDLE;
      fd_valid <= 1'b0;
    end else begin
      fd_valid <= fd_fire;
      unique case (st)
        ST_IDLE: begin
          if (in_ch.valid) begin
            vtx[0] <= in_ch.vertex_a_x;
            vtx[1] <= in_ch.vertex_a_y;
            vtx[2] <= in_ch.vertex_a_z;
            vtx[3] <= in_ch.vertex_b_x;
            vtx[4] <= in_ch.vertex_b_y;
            vtx[5] <= in_ch.vertex_b_z;
            vtx[6] <= in_ch.vertex_c_x;
            vtx[7] <= in_ch.vertex_c_y;
            vtx[8] <= in_ch.vertex_c_z;
            pos[0] <= in_ch.pos_x;
            pos[1] <= in_ch.pos_y;
            pos[2] <= in_ch.pos_z;
            cnt    <= cnt_eff;
            st     <= ST_EDGE;
          end
        end
        ST_EDGE: begin
          for (int j = 0; j < 3; j++) begin
            e[j]       <= 33'(vtx[3+j]) - 33'(vtx[j]);
            e[3+j]     <= 33'(vtx[6+j]) - 33'(vtx[j]);
            cmag[j]    <= smag[j];
            cen_neg[j] <= sum3[j][33];
          end
          st <= ST_SHIFT;
        end
        ST_SHIFT: begin
          for (int i = 0; i < 6; i++) begin
            es[i] <= e[i][32] ? -31'(emag[i] >> esh) : 31'(emag[i] >> esh);
          end
          // Centroid magnitude times the reciprocal of three, in two halves.
          for (int j = 0; j < 3; j++) begin
            cp_lo[j] <= cmag[j][16:0] * tcds_pkg::DIV3_RECIP;
            cp_hi[j] <= cmag[j][33:17] * tcds_pkg::DIV3_RECIP;
          end
          st <= ST_CROSS;
        end
        ST_CROSS: begin
          pr[0] <= es[1] * es[5];
          pr[1] <= es[2] * es[4];
          pr[2] <= es[2] * es[3];
          pr[3] <= es[0] * es[5];
          pr[4] <= es[0] * es[4];
          pr[5] <= es[1] * es[3];
          for (int j = 0; j < 3; j++) begin
            cen[j] <= cen_neg[j] ? -34'(cp_sum[j][67:35]) : 34'(cp_sum[j][67:35]);
          end
          st    <= ST_FEED_N;
        end
        ST_FEED_N: begin
          fd_x     <= 64'(pr[0]) - 64'(pr[1]);
          fd_y     <= 64'(pr[2]) - 64'(pr[3]);
          fd_z     <= 64'(pr[4]) - 64'(pr[5]);
          st       <= ST_WAIT_N;
        end
        ST_WAIT_N: begin
          if (su_valid) begin
            n[0] <= su_x;
            n[1] <= su_y;
            n[2] <= su_z;
            st   <= ST_FEED_U;
          end
        end
        ST_FEED_U: begin
          // A vertical normal takes the x axis; a zero normal gives a zero basis.
          if (n[0] == '0 && n[1] == '0) begin
            u[0] <= (n[2] != '0) ? 16'(tcds_pkg::ONE_Q14) : '0;
            u[1] <= '0;
            u[2] <= '0;
            st   <= ST_FEED_W;
          end else begin
            fd_x     <= -64'(n[1]);
            fd_y     <= 64'(n[0]);
            fd_z     <= '0;
            st       <= ST_WAIT_U;
          end
        end
        ST_WAIT_U: begin
          if (su_valid) begin
            u[0] <= su_x;
            u[1] <= su_y;
            u[2] <= su_z;
            st   <= ST_FEED_W;
          end
        end
        ST_FEED_W: begin
          fd_x     <= 64'(wp[0]) - 64'(wp[1]);
          fd_y     <= 64'(wp[2]) - 64'(wp[3]);
          fd_z     <= 64'(wp[4]) - 64'(wp[5]);
          st       <= ST_WAIT_W;
        end
        ST_WAIT_W: begin
          if (su_valid) begin
            w[0] <= su_x;
            w[1] <= su_y;
            w[2] <= su_z;
            gq   <= '0;
            grem <= {1'b0, cnt[6:1]};
            gidx <= '0;
            st   <= ST_POINTS;
          end
        end
        ST_POINTS: begin
          if (en) begin
            gq   <= gq + dv_num[31:0] + 32'(grem_wrap);
            grem <= grem_wrap ? 7'(grem_sum - {1'b0, cnt}) : grem_sum[6:0];
            gidx <= gidx + 6'd1;
            if (glast) st <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!front_busy) st <= ST_IDLE;
        end
        default: st <= ST_IDLE;
      endcase
    end
  end

  // Setup normalizer.
  tcds_unit3 u_setup_unit (
    .clk       (clk),
    .rst       (rst),
    .en        (1'b1),
    .in_valid  (fd_valid),
    .in_x      (fd_x),
    .in_y      (fd_y),
    .in_z      (fd_z),
    .in_tag    ('0),
    .out_valid (su_valid),
    .out_x     (su_x),
    .out_y     (su_y),
    .out_z     (su_z),
    .out_tag   ()
  );

  // Rotation pipeline and offset stages: valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= NS; k++) cv[k] <= 1'b0;
      vr <= 1'b0;
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
    end else if (en) begin
      cv[0] <= gen_fire;
      for (int k = 0; k < NS; k++) cv[k+1] <= cv[k];
      vr <= cv[NS];
      va <= vr;
      vb <= va;
      vc <= vb;
      vd <= vc;
    end
  end

  always_comb begin
    front_busy = vr | va | vb | vc | vd;
    for (int k = 0; k <= NS; k++) front_busy = front_busy | cv[k];
    xf    = cneg[NS] ? -cx[NS] : cx[NS];
    yf    = cneg[NS] ? -cy[NS] : cy[NS];
    rad_s = {1'b0, radius};
    for (int j = 0; j < 3; j++) rnd[j] = rp[j] + 64'sd134217728;
  end

  // Rotation pipeline and offset stages: data.
  always_ff @(posedge clk) begin
    if (en) begin
      // Fold the phase into the right half turn.
      cx[0]   <= 33'(tcds_pkg::CORDIC_GAIN_INV);
      cy[0]   <= '0;
      cz[0]   <= {ph[31], ph};
      cneg[0] <= ph_t[31];
      ct[0]   <= '{last: glast, idx: gidx};

      // One rotation step per stage.
      for (int k = 0; k < NS; k++) begin
        if (!cz[k][32]) begin
          cx[k+1] <= cx[k] - (cy[k] >>> k);
          cy[k+1] <= cy[k] + (cx[k] >>> k);
          cz[k+1] <= cz[k] - tcds_pkg::ATAN_TURN[k];
        end else begin
          cx[k+1] <= cx[k] + (cy[k] >>> k);
          cy[k+1] <= cy[k] - (cx[k] >>> k);
          cz[k+1] <= cz[k] + tcds_pkg::ATAN_TURN[k];
        end
        cneg[k+1] <= cneg[k];
        ct[k+1]   <= ct[k];
      end

      // Round cosine and sine to Q2.14.
      cs_r <= 17'((xf + 33'sd32768) >>> 16);
      sn_r <= 17'((yf + 33'sd32768) >>> 16);
      tr   <= ct[NS];

      // Basis products.
      for (int j = 0; j < 3; j++) begin
        pa[j] <= cs_r * u[j];
        pb[j] <= sn_r * w[j];
      end
      ta <= tr;

      for (int j = 0; j < 3; j++) nq[j] <= 34'(pa[j]) + 34'(pb[j]);
      tb <= ta;

      // Scale by the radius.
      for (int j = 0; j < 3; j++) rp[j] <= rad_s * $signed(nq[j][31:0]);
      tc <= tb;

      // Circle point minus observer position.
      for (int j = 0; j < 3; j++) begin
        dd[j] <= 38'(cen[j]) + 38'($signed(rnd[j][63:28])) - 38'(pos[j]);
      end
      td <= tc;
    end
  end

  // Output normalizer; its last stage is the output register.
  tcds_unit3 u_point_unit (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vd),
    .in_x      (64'(dd[0])),
    .in_y      (64'(dd[1])),
    .in_z      (64'(dd[2])),
    .in_tag    (td),
    .out_valid (pu_valid),
    .out_x     (pu_x),
    .out_y     (pu_y),
    .out_z     (pu_z),
    .out_tag   (pu_tag)
  );

  assign out_ch.valid       = pu_valid;
  assign out_ch.dir_x       = pu_x;
  assign out_ch.dir_y       = pu_y;
  assign out_ch.dir_z       = pu_z;
  assign out_ch.point_index = pu_tag.idx;
  assign out_ch.last        = pu_tag.last;

`ifndef SYNTH
  // A new triangle must not overwrite the basis while points still use it.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |-> !front_busy)
    else $error("triangle transfer while point stages busy");

  // The phase step divider has finished before points are issued.
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    (st == ST_POINTS) |-> (dv_cnt == '0))
    else $error("points issued before dividers finished");

  // Setup results only arrive while the sequencer waits for them.
  a_setup_result: assert property (@(posedge clk) disable iff (rst)
    su_valid |-> (st == ST_WAIT_N || st == ST_WAIT_U || st == ST_WAIT_W))
    else $error("unexpected setup normalizer result");
`endif

endmodule

>>> tb/triangle_circle_direction_sampler_top_tb.sv
// Self-checking testbench of the triangle circle direction sampler top level.
`timescale 1ns / 1ps

module triangle_circle_direction_sampler_top_tb;

  // One triangle with its observer position: a, b, c vertices then position, x/y/z each.
  typedef struct {
    logic signed [tcds_pkg::COORD_W-1:0] c [12];
  } triangle_t;

  // One emitted circle-point direction.
  typedef struct packed {
    tcds_pkg::dir_t             x;
    tcds_pkg::dir_t             y;
    tcds_pkg::dir_t             z;
    logic [tcds_pkg::IDX_W-1:0] idx;
    logic                       last;
  } direction_t;

  typedef struct packed {
    tcds_pkg::dir_t x;
    tcds_pkg::dir_t y;
    tcds_pkg::dir_t z;
  } unit_vec_t;

  // Scoreboard: computes the directions each triangle should produce and checks them.
  class direction_scoreboard;
    longint               radius;
    int                   count;
    direction_t           pending [$];
    int                   errors;

    function new();
      radius = 65536;
      count  = 64;
      errors = 0;
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b   = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v   = v - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    // Scales the vector so its largest magnitude is in [2^29, 2^30), then divides by the length.
    function unit_vec_t normalize(longint x, longint y, longint z);
      longint          v [3];
      longint unsigned m [3];
      longint unsigned mx, sum, r, q;
      int              len;
      logic signed [tcds_pkg::DIR_W-1:0] o [3];
      unit_vec_t       res;
      v[0] = x; v[1] = y; v[2] = z;
      for (int i = 0; i < 3; i++) m[i] = (v[i] < 0) ? -v[i] : v[i];
      mx  = m[0] | m[1] | m[2];
      sum = 0;
      len = 0;
      if (mx == 0) return '0;
      while (len < 64 && (mx >> len) != 0) len++;
      for (int i = 0; i < 3; i++) begin
        if (len > 30) m[i] = m[i] >> (len - 30);
        else m[i] = m[i] << (30 - len);
        sum = sum + m[i] * m[i];
      end
      r = int_sqrt(sum);
      for (int i = 0; i < 3; i++) begin
        q    = (m[i] * 64'd16384 + r / 2) / r;
        o[i] = (v[i] < 0) ? -q[tcds_pkg::DIR_W-1:0] : q[tcds_pkg::DIR_W-1:0];
      end
      res.x = o[0]; res.y = o[1]; res.z = o[2];
      return res;
    endfunction

    // Rotation of the gain-corrected unit vector by a phase given in 2^32 per turn.
    function void rotate_phase(logic [31:0] phase, output longint cs, output longint sn);
      longint atan_step [tcds_pkg::CORDIC_STEPS];
      longint x, y, z, nx;
      logic   neg;
      logic [31:0] sum;
      atan_step = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
        64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
        64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518};
      x   = tcds_pkg::CORDIC_GAIN_INV;
      y   = 0;
      sum = phase + 32'h40000000;
      neg = sum[31];
      if (neg) phase = phase + 32'h80000000;
      z = longint'($signed(phase));
      for (int k = 0; k < tcds_pkg::CORDIC_STEPS; k++) begin
        if (z >= 0) begin
          nx = x - (y >>> k); y = y + (x >>> k); z = z - atan_step[k];
        end else begin
          nx = x + (y >>> k); y = y - (x >>> k); z = z + atan_step[k];
        end
        x = nx;
      end
      if (neg) begin
        x = -x; y = -y;
      end
      cs = (x + 32768) >>> 16;
      sn = (y + 32768) >>> 16;
    endfunction

    // Works out every direction of one accepted triangle and queues them.
    function void note_triangle(triangle_t t);
      longint          vtx [12];
      longint          e [6];
      longint          cen [3];
      longint          nv [3], uv [3], wv [3];
      longint          d [3];
      longint unsigned em [6];
      longint unsigned emax, sm, cnt, phase;
      longint          sum3, cs, sn, nq, off;
      int              sh;
      unit_vec_t       n, u, w, dv;
      direction_t      res;
      emax = 0;
      sh   = 0;
      for (int i = 0; i < 12; i++) vtx[i] = t.c[i];
      for (int j = 0; j < 3; j++) begin
        e[j]     = vtx[3 + j] - vtx[j];
        e[3 + j] = vtx[6 + j] - vtx[j];
      end
      for (int i = 0; i < 6; i++) begin
        em[i] = (e[i] < 0) ? -e[i] : e[i];
        emax  = emax | em[i];
      end
      while ((emax >> sh) >= (64'd1 << 30)) sh++;
      for (int i = 0; i < 6; i++) e[i] = (e[i] < 0) ? -longint'(em[i] >> sh) : longint'(em[i] >> sh);
      n = normalize(e[1] * e[5] - e[2] * e[4], e[2] * e[3] - e[0] * e[5],
                    e[0] * e[4] - e[1] * e[3]);
      nv[0] = n.x; nv[1] = n.y; nv[2] = n.z;

      // Vertical normal takes the x axis as first basis vector.
      if (nv[0] == 0 && nv[1] == 0) begin
        u = '0;
        if (nv[2] != 0) u.x = tcds_pkg::ONE_Q14;
      end else begin
        u = normalize(-nv[1], nv[0], 0);
      end
      uv[0] = u.x; uv[1] = u.y; uv[2] = u.z;
      w = normalize(nv[1] * uv[2] - nv[2] * uv[1], nv[2] * uv[0] - nv[0] * uv[2],
                    nv[0] * uv[1] - nv[1] * uv[0]);
      wv[0] = w.x; wv[1] = w.y; wv[2] = w.z;

      // Centroid rounded to nearest, symmetric in sign.
      for (int j = 0; j < 3; j++) begin
        sum3   = vtx[j] + vtx[3 + j] + vtx[6 + j];
        sm     = (((sum3 < 0) ? -sum3 : sum3) + 1) / 3;
        cen[j] = (sum3 < 0) ? -longint'(sm) : longint'(sm);
      end

      cnt = count;
      if (cnt > tcds_pkg::MAX_POINTS) cnt = tcds_pkg::MAX_POINTS;
      if (cnt == 0) cnt = 1;

      for (longint unsigned i = 0; i < cnt; i++) begin
        phase = ((i << 32) + cnt / 2) / cnt;
        rotate_phase(phase[31:0], cs, sn);
        for (int j = 0; j < 3; j++) begin
          nq   = cs * uv[j] + sn * wv[j];
          off  = (radius * nq + (64'sd1 <<< 27)) >>> 28;
          d[j] = cen[j] + off - vtx[9 + j];
        end
        dv       = normalize(d[0], d[1], d[2]);
        res.x    = dv.x;
        res.y    = dv.y;
        res.z    = dv.z;
        res.idx  = i[tcds_pkg::IDX_W-1:0];
        res.last = (i + 1 == cnt);
        pending  = {pending, res};
      end
    endfunction

    // Compares one transferred direction with the oldest one still owed.
    function void check_direction(direction_t got);
      direction_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected direction x=%0d y=%0d z=%0d idx=%0d last=%0b",
                 $time, got.x, got.y, got.z, got.idx, got.last);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.x !== want.x) begin
        $display("%0t: dir_x expected %0d actual %0d", $time, want.x, got.x);
        errors++;
      end
      if (got.y !== want.y) begin
        $display("%0t: dir_y expected %0d actual %0d", $time, want.y, got.y);
        errors++;
      end
      if (got.z !== want.z) begin
        $display("%0t: dir_z expected %0d actual %0d", $time, want.z, got.z);
        errors++;
      end
      if (got.idx !== want.idx) begin
        $display("%0t: point_index expected %0d actual %0d", $time, want.idx, got.idx);
        errors++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last expected %0b actual %0b", $time, want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  localparam int IDLE_LIMIT = 6000;
  localparam int LONG_HOLD  = 1500;

  logic                        clk;
  logic                        rst;
  logic                        cfg_we;
  logic [1:0]                  cfg_index;
  logic [tcds_pkg::RAD_W-1:0]  cfg_data;
  logic                        in_done;
  logic                        no_idle;
  logic                        hold_req;
  int                          stall_left;
  int                          idle_cycles;
  direction_scoreboard         sb;

  tcds_in_if  in_if ();
  tcds_out_if out_if ();

  triangle_circle_direction_sampler_top dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_ch    (in_if),
    .out_ch   (out_if)
  );

  // Clock, 2 ns period.
  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  // Short gaps mostly, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Transfer monitors, sampled at the rising edge.
  always @(posedge clk) begin
    triangle_t  t;
    direction_t got;
    in_done <= in_if.valid && in_if.ready && !rst;
    if (!rst && in_if.valid && in_if.ready) begin
      t.c = '{in_if.vertex_a_x, in_if.vertex_a_y, in_if.vertex_a_z,
              in_if.vertex_b_x, in_if.vertex_b_y, in_if.vertex_b_z,
              in_if.vertex_c_x, in_if.vertex_c_y, in_if.vertex_c_z,
              in_if.pos_x, in_if.pos_y, in_if.pos_z};
      sb.note_triangle(t);
    end
    if (!rst && out_if.valid && out_if.ready) begin
      got = '{out_if.dir_x, out_if.dir_y, out_if.dir_z, out_if.point_index, out_if.last};
      sb.check_direction(got);
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (rst || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
        $display("[triangle_circle_direction_sampler_top] ERROR");
        $finish;
      end
    end
  end

  // Receiver: random stalls, and one long hold-off when asked.
  initial begin
    out_if.ready = 1'b0;
    stall_left   = 0;
    forever begin
      @(negedge clk);
      if (rst) begin
        out_if.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req     = 1'b0;
        stall_left   = LONG_HOLD;
        out_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else begin
        stall_left   = pick_gap();
        out_if.ready <= (stall_left == 0);
      end
    end
  end

  function automatic triangle_t make_triangle(longint ax, longint ay, longint az,
                                              longint bx, longint by, longint bz,
                                              longint cx, longint cy, longint cz,
                                              longint px, longint py, longint pz);
    triangle_t t;
    t.c = '{ax[31:0], ay[31:0], az[31:0], bx[31:0], by[31:0], bz[31:0],
            cx[31:0], cy[31:0], cz[31:0], px[31:0], py[31:0], pz[31:0]};
    return t;
  endfunction

  // Random triangles: mostly compact well-formed ones, some flat, degenerate or raw noise.
  function automatic triangle_t random_triangle();
    triangle_t t;
    longint    ctr [3];
    int        kind;
    kind = $urandom_range(0, 9);
    for (int j = 0; j < 3; j++) ctr[j] = longint'($signed($urandom())) >>> 7;
    for (int i = 0; i < 12; i++) begin
      if (kind < 2) t.c[i] = $urandom();
      else if (i < 9) t.c[i] = ctr[i % 3] + $urandom_range(0, 131072) - 65536;
      else t.c[i] = ctr[i % 3] + $urandom_range(0, 2097152) - 1048576;
    end
    if (kind == 2) begin
      // Flat in z, so the normal is vertical.
      t.c[5] = t.c[2];
      t.c[8] = t.c[2];
    end else if (kind == 3) begin
      // Collinear or coincident vertices.
      for (int j = 0; j < 3; j++) t.c[6 + j] = t.c[3 + j];
    end
    return t;
  endfunction

  task automatic send_triangle(triangle_t t, int gap);
    in_if.valid      <= 1'b1;
    in_if.vertex_a_x <= t.c[0];  in_if.vertex_a_y <= t.c[1];  in_if.vertex_a_z <= t.c[2];
    in_if.vertex_b_x <= t.c[3];  in_if.vertex_b_y <= t.c[4];  in_if.vertex_b_z <= t.c[5];
    in_if.vertex_c_x <= t.c[6];  in_if.vertex_c_y <= t.c[7];  in_if.vertex_c_z <= t.c[8];
    in_if.pos_x      <= t.c[9];  in_if.pos_y      <= t.c[10]; in_if.pos_z      <= t.c[11];
    do @(negedge clk); while (!in_done);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Stops offering and waits until every owed direction has come out.
  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] index, longint value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value[tcds_pkg::RAD_W-1:0];
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (index == tcds_pkg::REG_RADIUS) sb.radius = value & 64'h7FFFFFFF;
    else sb.count = value & 64'h7F;
  endtask

  localparam longint MAXC = 64'sh7FFFFFFF;
  localparam longint MINC = -64'sh80000000;

  // Main sequence.
  initial begin
    sb       = new();
    rst      = 1'b1;
    no_idle  = 1'b0;
    hold_req = 1'b0;
    cfg_we   = 1'b0;
    cfg_index = tcds_pkg::REG_RADIUS;
    cfg_data = '0;
    in_if.valid = 1'b0;
    in_if.vertex_a_x = '0; in_if.vertex_a_y = '0; in_if.vertex_a_z = '0;
    in_if.vertex_b_x = '0; in_if.vertex_b_y = '0; in_if.vertex_b_z = '0;
    in_if.vertex_c_x = '0; in_if.vertex_c_y = '0; in_if.vertex_c_z = '0;
    in_if.pos_x = '0; in_if.pos_y = '0; in_if.pos_z = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // Reset settings: flat, tilted, degenerate and extreme triangles.
    send_triangle(make_triangle(0, 0, 0, 65536, 0, 0, 0, 65536, 0, 0, 0, 327680), pick_gap());
    send_triangle(make_triangle(0, 0, 0, 0, 65536, 0, 0, 0, 65536, -200000, 30, 7), pick_gap());
    send_triangle(make_triangle(5, 5, 5, 5, 5, 5, 5, 5, 5, 100000, -100000, 0), pick_gap());
    send_triangle(make_triangle(0, 0, 0, 65536, 65536, 65536, 131072, 131072, 131072,
                                0, 0, 0), pick_gap());
    send_triangle(make_triangle(MAXC, MAXC, MAXC, MINC, MINC, MINC, MAXC, MINC, 0,
                                MINC, MINC, MINC), pick_gap());
    send_triangle(make_triangle(MINC, MINC, MINC, MINC, MINC, MINC, MINC, MINC, MINC,
                                MAXC, MAXC, MAXC), pick_gap());
    send_triangle(make_triangle(MAXC, MAXC, MAXC, MAXC, MINC, MAXC, MINC, MAXC, MINC,
                                MAXC, MAXC, MAXC), pick_gap());
    send_triangle(make_triangle(-3, 1, 9, 70000, -2, 4, 12, 90000, -50000, 1, 2, 3), 0);
    drain();

    // Zero radius with a single point: observer on the centroid gives a zero direction.
    write_reg(tcds_pkg::REG_RADIUS, 0);
    write_reg(tcds_pkg::REG_COUNT, 1);
    send_triangle(make_triangle(3, 3, 3, 3, 3, 3, 3, 3, 3, 3, 3, 3), pick_gap());
    send_triangle(make_triangle(0, 0, 0, 300, 0, 0, 0, 300, 0, 100, 100, 0), pick_gap());
    send_triangle(make_triangle(0, 0, 0, 65536, 0, 0, 0, 65536, 0, 0, 0, 65536), 0);
    drain();

    // Largest radius and a point count beyond the cap.
    write_reg(tcds_pkg::REG_RADIUS, MAXC);
    write_reg(tcds_pkg::REG_COUNT, 127);
    send_triangle(make_triangle(0, 0, 0, 65536, 0, 0, 0, 65536, 0, 0, 0, 327680), pick_gap());
    send_triangle(make_triangle(MINC, 0, MAXC, MAXC, MINC, 0, 0, MAXC, MINC, 7, 7, 7), 0);
    drain();

    // Point count of zero behaves as one.
    write_reg(tcds_pkg::REG_COUNT, 0);
    write_reg(tcds_pkg::REG_RADIUS, 65536);
    send_triangle(make_triangle(0, 0, 0, 65536, 0, 0, 0, 65536, 0, 0, 0, 327680), pick_gap());
    send_triangle(random_triangle(), 0);
    drain();

    // Random phases with varied settings.
    for (int ph = 0; ph < 10; ph++) begin
      int sel;
      sel = $urandom_range(0, 3);
      write_reg(tcds_pkg::REG_RADIUS, (sel == 0) ? 0 : (sel == 1) ? $urandom_range(1, 1 << 20) :
                            (sel == 2) ? 65536 : {1'b0, $urandom()} >> 1);
      sel = $urandom_range(0, 9);
      write_reg(tcds_pkg::REG_COUNT, (sel < 7) ? $urandom_range(1, 8) : (sel == 7) ? 64 :
                           (sel == 8) ? $urandom_range(65, 127) : $urandom_range(0, 40));
      no_idle = (ph == 5);
      if (ph == 3) begin
        // Long receiver hold-off while triangles keep coming back to back.
        hold_req = 1'b1;
        for (int i = 0; i < 8; i++) send_triangle(random_triangle(), 0);
      end
      for (int i = 0; i < 41; i++) send_triangle(random_triangle(), pick_gap());
      drain();
      no_idle = 1'b0;
    end

    repeat (300) @(negedge clk);
    if (sb.pending.size() != 0)
      $display("%0t: %0d directions never arrived", $time, sb.pending.size());
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("[triangle_circle_direction_sampler_top] OK");
    end else begin
      $display("[triangle_circle_direction_sampler_top] ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/tcds_pkg.sv
rtl/core/tcds_if.sv
rtl/core/tcds_unit3.sv
rtl/core/triangle_circle_direction_sampler_top.sv
tb/triangle_circle_direction_sampler_top_tb.sv
